// ===== src/bbc_pkg.sv =====
package bbc_pkg;

	localparam int NUM_SLOTS = 32;
	localparam int IDX_W     = $clog2(NUM_SLOTS);
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int TAG_W     = 48;

	typedef logic [2:0] kind_t;
	localparam kind_t KIND_GRANT   = 3'd0;
	localparam kind_t KIND_WB      = 3'd1;
	localparam kind_t KIND_BUSY    = 3'd2;
	localparam kind_t KIND_RELEASE = 3'd3;
	localparam kind_t KIND_BAD_PUT = 3'd4;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [15:0] device;
		logic [31:0] block_number;
		logic [4:0]  slot_index;
		logic        mark_dirty;
	} req_t;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  out_slot;
		logic [15:0] out_device;
		logic [31:0] out_block;
		logic        needs_fill;
		logic        last;
	} rsp_t;

endpackage

// ===== src/bbc_ram.sv =====
module bbc_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/block_buffer_cache_lru_top.sv =====
// Buffer cache slot manager with least-recently-released reuse order.
//
// Request channel: a transaction is taken at a rising edge with start high
// and busy low. req.cmd selects get (lookup/claim by device and block) or
// put (release of a held slot, optionally marking it dirty).
// Result channel: rsp_valid marks rsp for exactly one cycle; the receiver
// cannot stall it. Every transaction yields one or more results, the final
// one carrying rsp.last.
// A put answers in the cycle after acceptance and busy stays low.
// A get runs a serial tag lookup through the tag RAM, one slot per cycle,
// and answers a hit once the matching slot has been checked; after the last
// slot a miss takes a victim, or answers busy if no slot is free. Each dirty
// victim first goes through a tag RAM read, then the write-back result,
// before the next victim is tried; the grant follows in the cycle after a clean victim is found.
// A new get or put is not taken until busy drops with the final result.
// Reset: all slots invalid, clean and free, free order 0..NUM_SLOTS-1.
// The tag RAM is not cleared; a tag only counts as a hit once its slot is valid.
module block_buffer_cache_lru_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  bbc_pkg::req_t req,
	output logic          rsp_valid,
	output bbc_pkg::rsp_t rsp
);
	import bbc_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_SRCH, S_VICT, S_WB} state_t;

	state_t               state_q;
	req_t                 req_q;
	logic [IDX_W-1:0]     cnt_q;
	logic                 chk_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [IDX_W-1:0]     victim_q;
	logic [NUM_SLOTS-1:0] valid_q, dirty_q, held_q;
	logic [IDX_W-1:0]     rank_q [NUM_SLOTS];
	logic [CNT_W-1:0]     count_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	// tag RAM
	logic               ram_we;
	logic [IDX_W-1:0]   ram_raddr;
	logic [TAG_W-1:0]   ram_rdata;
	logic [IDX_W-1:0]   vict_idx;

	bbc_ram #(.DEPTH(NUM_SLOTS), .WIDTH(TAG_W)) u_tags (
		.clk   (clk),
		.we    (ram_we),
		.waddr (vict_idx),
		.wdata ({req_q.device, req_q.block_number}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// oldest free slot: free and at rank zero
	always_comb begin
		vict_idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!held_q[i] && rank_q[i] == '0) begin
				vict_idx = IDX_W'(i);
			end
		end
	end

	logic accept, put_ok, hit, srch_end;
	logic [IDX_W-1:0] put_idx;

	assign accept    = start && !busy;
	assign put_idx   = IDX_W'(req.slot_index);
	assign put_ok    = (32'(req.slot_index) < NUM_SLOTS) && held_q[put_idx];
	assign hit       = chk_s1 && valid_q[idx_s1]
	                   && ram_rdata == {req_q.device, req_q.block_number};
	assign srch_end  = chk_s1 && idx_s1 == IDX_W'(NUM_SLOTS - 1);
	assign ram_raddr = (state_q == S_SRCH) ? cnt_q : vict_idx;
	assign ram_we    = (state_q == S_VICT) && !dirty_q[vict_idx];

	assign busy      = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	function automatic rsp_t mk_rsp(kind_t k, logic [IDX_W-1:0] s, logic [TAG_W-1:0] t,
	                                logic fill, logic lst);
		rsp_t r;
		r.kind       = k;
		r.out_slot   = 5'(s);
		r.out_device = t[TAG_W-1:32];
		r.out_block  = t[31:0];
		r.needs_fill = fill;
		r.last       = lst;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			chk_s1      <= 1'b0;
			valid_q     <= '0;
			dirty_q     <= '0;
			held_q      <= '0;
			count_q     <= CNT_W'(NUM_SLOTS);
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				rank_q[i] <= IDX_W'(i);
			end
		end else begin
			rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q <= req;
						if (req.cmd == CMD_PUT) begin
							rsp_valid_q <= 1'b1;
							if (put_ok) begin
								held_q[put_idx] <= 1'b0;
								if (req.mark_dirty) begin
									dirty_q[put_idx] <= 1'b1;
								end
								rank_q[put_idx] <= IDX_W'(count_q);
								count_q         <= count_q + 1'b1;
								rsp_q <= mk_rsp(KIND_RELEASE, put_idx, '0, 1'b0, 1'b1);
							end else begin
								rsp_q <= mk_rsp(KIND_BAD_PUT, put_idx, '0, 1'b0, 1'b1);
							end
						end else begin
							cnt_q   <= '0;
							chk_s1  <= 1'b0;
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					chk_s1 <= 1'b1;
					idx_s1 <= cnt_q;
					cnt_q  <= cnt_q + 1'b1;
					if (hit) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (held_q[idx_s1]) begin
							rsp_q <= mk_rsp(KIND_BUSY, idx_s1, '0, 1'b0, 1'b1);
						end else begin
							for (int i = 0; i < NUM_SLOTS; i++) begin
								if (!held_q[i] && rank_q[i] > rank_q[idx_s1]) begin
									rank_q[i] <= rank_q[i] - 1'b1;
								end
							end
							held_q[idx_s1] <= 1'b1;
							count_q        <= count_q - 1'b1;
							rsp_q <= mk_rsp(KIND_GRANT, idx_s1, ram_rdata, 1'b0, 1'b1);
						end
					end else if (srch_end) begin
						if (count_q == '0) begin
							rsp_valid_q <= 1'b1;
							rsp_q       <= mk_rsp(KIND_BUSY, '0, '0, 1'b0, 1'b1);
							state_q     <= S_IDLE;
						end else begin
							state_q <= S_VICT;
						end
					end
				end
				S_VICT: begin
					victim_q <= vict_idx;
					if (dirty_q[vict_idx]) begin
						state_q <= S_WB;
					end else begin
						// tag write happens in this cycle through ram_we
						for (int i = 0; i < NUM_SLOTS; i++) begin
							if (!held_q[i] && IDX_W'(i) != vict_idx) begin
								rank_q[i] <= rank_q[i] - 1'b1;
							end
						end
						valid_q[vict_idx] <= 1'b1;
						held_q[vict_idx]  <= 1'b1;
						count_q           <= count_q - 1'b1;
						rsp_valid_q       <= 1'b1;
						rsp_q <= mk_rsp(KIND_GRANT, vict_idx,
						                {req_q.device, req_q.block_number}, 1'b1, 1'b1);
						state_q <= S_IDLE;
					end
				end
				S_WB: begin
					// victim tag now on ram_rdata; clean it and rotate to tail
					for (int i = 0; i < NUM_SLOTS; i++) begin
						if (!held_q[i] && IDX_W'(i) != victim_q) begin
							rank_q[i] <= rank_q[i] - 1'b1;
						end
					end
					rank_q[victim_q]  <= IDX_W'(count_q - 1'b1);
					dirty_q[victim_q] <= 1'b0;
					rsp_valid_q       <= 1'b1;
					rsp_q   <= mk_rsp(KIND_WB, victim_q, ram_rdata, 1'b0, 1'b0);
					state_q <= S_VICT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/bbc_chk.sv =====
module bbc_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input bbc_pkg::req_t req,
	input logic          rsp_valid,
	input bbc_pkg::rsp_t rsp
);
	import bbc_pkg::*;

	a_put_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.cmd == CMD_PUT |=> rsp_valid && rsp.last && !busy)
		else $error("put not answered next cycle");

	a_get_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.cmd == CMD_GET |=> busy && !rsp_valid)
		else $error("get did not raise busy");

	a_wb_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_WB |-> !rsp.last && busy)
		else $error("write-back marked last");

	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !busy |-> rsp.last)
		else $error("result while idle not last");

endmodule

bind block_buffer_cache_lru_top bbc_chk u_bbc_chk (.*);
